// ----- rtl/core/arp_tab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_tab_pkg
// Shared types, operation codes and defaults for the ARP table with aging.
// ----------------------------------------------------------------------------
package arp_tab_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned AGE_W       = 16;
  localparam logic [15:0] MAX_AGE_RST = 16'd60;

  // operation codes carried in the kind field
  localparam logic [2:0] OP_UPDATE  = 3'd0;
  localparam logic [2:0] OP_PERSIST = 3'd1;
  localparam logic [2:0] OP_QRY_IP  = 3'd2;
  localparam logic [2:0] OP_QRY_DEV = 3'd3;
  localparam logic [2:0] OP_AGE     = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [7:0]  device_id;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hit_ip;
    logic [47:0] hit_mac;
    logic [7:0]  hit_device;
    logic [15:0] hit_age;
    logic        hit_persistent;
    logic        removed_any;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [7:0]       device;
    logic [AGE_W-1:0] age;
    logic             persistent;
  } entry_t;

  // verdict of the slot unit on one entry
  typedef struct packed {
    logic   hit;      // key matches under the current operation
    logic   expired;  // age tick: entry leaves the table
    entry_t nxt;      // entry after the operation
  } slot_res_t;

endpackage

// ----- rtl/core/arp_table_with_aging_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_table_with_aging_top
// ARP table in insertion order with aging: update, persist, query by IP,
// query by device and age tick, one slot scanned per cycle.
// ----------------------------------------------------------------------------
//  channel  ports                     handshake
//  input    start, busy, in_data      beat taken when start && !busy
//  result   out_strobe, out_data      one cycle per beat, cannot be held off
//  config   cfg_we, cfg_wdata         max_age written when cfg_we
//
//  An operation scans all N stored entries before the strobe, N the entry count
//  (no scan for an empty table or an unknown kind); the scan reads one slot per
//  cycle through the single read port of the entry store.
//  busy is high from the cycle after accept until the result strobe.
//  Reset is synchronous, active low, and empties the table; max_age is 60.
// ----------------------------------------------------------------------------
module arp_table_with_aging_top #(
  parameter int unsigned TABLE_DEPTH = arp_tab_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  arp_tab_pkg::in_t   in_data,
  output logic               out_strobe,
  output arp_tab_pkg::out_t  out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import arp_tab_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] pidx_r;
  logic             vld_r;
  logic             found_r, found_nxt;
  logic             removed_r, removed_nxt;
  entry_t           hit_e_r, hit_e_nxt;
  in_t              req_r;
  logic [15:0]      max_age_r;
  logic             out_strobe_r;
  out_t             out_r, out_nxt;

  logic             issue;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;
  entry_t           new_e;
  slot_res_t        sres;

  arp_tab_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  arp_tab_alu u_alu (
    .kind    (req_r.kind),
    .ip_key  (req_r.ip_addr),
    .dev_key (req_r.device_id),
    .max_age (max_age_r),
    .ent     (mem_rdata),
    .res     (sres)
  );

  assign issue = (state_r == ST_SCAN) && (rd_idx_r < cnt_r);

  always_comb begin
    new_e.ip         = req_r.ip_addr;
    new_e.mac        = req_r.mac_addr;
    new_e.device     = req_r.device_id;
    new_e.age        = max_age_r;
    new_e.persistent = 1'b0;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    wr_ptr_nxt  = wr_ptr_r;
    found_nxt   = found_r;
    removed_nxt = removed_r;
    hit_e_nxt   = hit_e_r;
    mem_we      = 1'b0;
    mem_waddr   = pidx_r;
    mem_wdata   = sres.nxt;
    out_nxt     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_idx_nxt  = '0;
          wr_ptr_nxt  = '0;
          found_nxt   = 1'b0;
          removed_nxt = 1'b0;
          if (cnt_r == '0 || in_data.kind > OP_AGE) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (vld_r) begin
          priority case (req_r.kind)
            OP_UPDATE: begin
              if (sres.hit && !found_r) begin
                mem_we    = 1'b1;
                found_nxt = 1'b1;
                hit_e_nxt = sres.nxt;
              end
            end
            OP_PERSIST: begin
              if (sres.hit) begin
                mem_we = 1'b1;
                if (!found_r) begin
                  found_nxt = 1'b1;
                  hit_e_nxt = sres.nxt;
                end
              end
            end
            OP_QRY_IP, OP_QRY_DEV: begin
              if (sres.hit && !found_r) begin
                found_nxt = 1'b1;
                hit_e_nxt = sres.nxt;
              end
            end
            OP_AGE: begin
              // compact: survivors move down to the write pointer
              if (sres.expired) begin
                removed_nxt = 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = wr_ptr_r[IDX_W-1:0];
                wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
              end
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
        if (!issue && !vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
        if (found_r) begin
          out_nxt.found          = 1'b1;
          out_nxt.hit_ip         = hit_e_r.ip;
          out_nxt.hit_mac        = hit_e_r.mac;
          out_nxt.hit_device     = hit_e_r.device;
          out_nxt.hit_age        = hit_e_r.persistent ? '0 : hit_e_r.age;
          out_nxt.hit_persistent = hit_e_r.persistent;
        end
        if (req_r.kind == OP_AGE) begin
          out_nxt.removed_any = removed_r;
          cnt_nxt             = wr_ptr_r;
        end
        if (req_r.kind == OP_UPDATE && !found_r) begin
          if (cnt_r == FULL_CNT) begin
            out_nxt.table_full = 1'b1;
          end else begin
            // append the new address at the tail
            mem_we    = 1'b1;
            mem_waddr = cnt_r[IDX_W-1:0];
            mem_wdata = new_e;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      vld_r        <= 1'b0;
      max_age_r    <= MAX_AGE_RST;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      vld_r        <= issue;
      out_strobe_r <= (state_r == ST_FINISH);
      if (cfg_we) begin
        max_age_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    pidx_r    <= rd_idx_r[IDX_W-1:0];
    found_r   <= found_nxt;
    removed_r <= removed_nxt;
    hit_e_r   <= hit_e_nxt;
    out_r     <= out_nxt;
    if (state_r == ST_IDLE && start) begin
      req_r <= in_data;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (wr_ptr_r <= rd_idx_r))
    else $error("compaction pointer overtook the read pointer");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_FINISH))
    else $error("result strobe without a finish cycle");
`endif

endmodule

// ----- rtl/core/arp_tab_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_tab_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arp_tab_mem #(
  parameter int unsigned DEPTH = arp_tab_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  arp_tab_pkg::entry_t        wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output arp_tab_pkg::entry_t        rdata
);
  import arp_tab_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/arp_tab_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_tab_alu
// Shared slot unit: key compare, age refresh, persist mark and age decrement
// for the one entry that the scan presents in this cycle.
// ----------------------------------------------------------------------------
module arp_tab_alu (
  input  logic [2:0]             kind,
  input  logic [31:0]            ip_key,
  input  logic [7:0]             dev_key,
  input  logic [15:0]            max_age,
  input  arp_tab_pkg::entry_t    ent,
  output arp_tab_pkg::slot_res_t res
);
  import arp_tab_pkg::*;

  logic ip_eq;
  logic dev_eq;

  assign ip_eq  = (ent.ip == ip_key);
  assign dev_eq = (ent.device == dev_key);

  always_comb begin
    res.hit     = 1'b0;
    res.expired = 1'b0;
    res.nxt     = ent;
    unique case (kind)
      OP_UPDATE: begin
        res.hit = ip_eq;
        if (!ent.persistent) begin
          res.nxt.age = max_age;
        end
      end
      OP_PERSIST: begin
        res.hit            = ip_eq;
        res.nxt.persistent = 1'b1;
        res.nxt.age        = '0;
      end
      OP_QRY_IP: begin
        res.hit = ip_eq;
      end
      OP_QRY_DEV: begin
        res.hit = dev_eq;
      end
      OP_AGE: begin
        res.expired = !ent.persistent && (ent.age == '0);
        if (!ent.persistent) begin
          res.nxt.age = ent.age - AGE_W'(1);
        end
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

// ----- tb/arp_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_table_checker
// Watches the command, result and max_age ports of the ARP table, keeps its
// own copy of the table, predicts one reply per accepted command and
// compares every result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module arp_table_checker #(
  parameter int unsigned DEPTH = arp_tab_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  arp_tab_pkg::in_t  in_data,
  input  logic              out_strobe,
  input  arp_tab_pkg::out_t out_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  import arp_tab_pkg::*;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  dev;
    logic [15:0] age;
    logic        pinned;
  } row_t;

  row_t        rows [DEPTH];
  int unsigned used = 0;
  logic [15:0] fresh_age = MAX_AGE_RST;
  out_t        due_replies [$];
  int unsigned mismatches = 0;

  function automatic out_t show_row(input int idx);
    out_t r;
    r = '0;
    r.found          = 1'b1;
    r.hit_ip         = rows[idx].ip;
    r.hit_mac        = rows[idx].mac;
    r.hit_device     = rows[idx].dev;
    r.hit_age        = rows[idx].pinned ? 16'd0 : rows[idx].age;
    r.hit_persistent = rows[idx].pinned;
    return r;
  endfunction

  function automatic int first_ip(input logic [31:0] ip);
    int hit;
    hit = -1;
    for (int i = 0; i < used; i++)
      if (hit < 0 && rows[i].ip == ip) hit = i;
    return hit;
  endfunction

  // apply one command to the table copy and return the reply it yields
  function automatic out_t table_apply(input in_t op);
    out_t        r;
    int          hit;
    int unsigned w;
    r   = '0;
    hit = -1;
    case (op.kind)
      OP_UPDATE: begin
        hit = first_ip(op.ip_addr);
        if (hit >= 0) begin
          if (!rows[hit].pinned) rows[hit].age = fresh_age;
          r = show_row(hit);
        end else if (used >= DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          rows[used].ip     = op.ip_addr;
          rows[used].mac    = op.mac_addr;
          rows[used].dev    = op.device_id;
          rows[used].age    = fresh_age;
          rows[used].pinned = 1'b0;
          used++;
        end
      end
      OP_PERSIST: begin
        // mark every copy of the ip, report the first
        for (int i = 0; i < used; i++) begin
          if (rows[i].ip == op.ip_addr) begin
            rows[i].pinned = 1'b1;
            rows[i].age    = '0;
            if (hit < 0) hit = i;
          end
        end
        if (hit >= 0) r = show_row(hit);
      end
      OP_QRY_IP: begin
        hit = first_ip(op.ip_addr);
        if (hit >= 0) r = show_row(hit);
      end
      OP_QRY_DEV: begin
        for (int i = 0; i < used; i++)
          if (hit < 0 && rows[i].dev == op.device_id) hit = i;
        if (hit >= 0) r = show_row(hit);
      end
      OP_AGE: begin
        // drop expired entries and close the gaps in order
        w = 0;
        for (int i = 0; i < used; i++) begin
          if (!rows[i].pinned && rows[i].age == '0) begin
            r.removed_any = 1'b1;
          end else begin
            if (!rows[i].pinned) rows[i].age = rows[i].age - 16'd1;
            rows[w] = rows[i];
            w++;
          end
        end
        used = w;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      used      = 0;
      fresh_age = MAX_AGE_RST;
      due_replies.delete();
    end else begin
      if (out_strobe) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing outstanding: %h", $time, out_data);
        end else begin
          want = due_replies.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch (exp/got) found %b/%b ip %h/%h mac %h/%h ",
                        "dev %h/%h age %0d/%0d pers %b/%b removed %b/%b full %b/%b"},
                       $time, want.found, out_data.found, want.hit_ip, out_data.hit_ip,
                       want.hit_mac, out_data.hit_mac, want.hit_device,
                       out_data.hit_device, want.hit_age, out_data.hit_age,
                       want.hit_persistent, out_data.hit_persistent,
                       want.removed_any, out_data.removed_any,
                       want.table_full, out_data.table_full);
          end
        end
      end
      if (cfg_we) fresh_age = cfg_wdata;
      if (start && !busy) due_replies.insert(due_replies.size(), table_apply(in_data));
    end
    fail_count <= mismatches;
    pending    <= due_replies.size();
  end

endmodule

// ----- tb/tb_arp_table_with_aging_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_table_with_aging_top
// Drives the ARP table with a directed run over every operation, the field
// extremes, persistence, full table and extreme max_age values, then with
// random command phases at several max_age settings; the checker beside the
// block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_arp_table_with_aging_top;
  import arp_tab_pkg::*;

  localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;
  localparam int unsigned POOL_SIZE      = 20;
  localparam int unsigned PHASE_COUNT    = 8;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  in_t         in_data   = '0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        busy;
  logic        out_strobe;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  logic        quiet  = 1'b0;
  logic [31:0] ip_pool [POOL_SIZE];
  logic [15:0] phase_age [PHASE_COUNT];

  arp_table_with_aging_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  arp_table_checker #(.DEPTH(DEPTH_DEF)) reply_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] any_mac();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[47:0];
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [7:0] pick_dev();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 5));
  endfunction

  function automatic logic [2:0] pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 36) return OP_UPDATE;
    if (roll < 41) return OP_PERSIST;
    if (roll < 61) return OP_QRY_IP;
    if (roll < 76) return OP_QRY_DEV;
    if (roll < 95) return OP_AGE;
    return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // present one beat, hold until taken, then maybe idle for a burst
  task automatic issue(input logic [2:0] kind, input logic [31:0] ip,
                       input logic [47:0] mac, input logic [7:0] dev);
    in_t         beat;
    int unsigned gap;
    beat.kind      = kind;
    beat.ip_addr   = ip;
    beat.mac_addr  = mac;
    beat.device_id = dev;
    start   <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all outstanding replies, then write max_age
  task automatic set_max_age(input logic [15:0] age);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= age;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    logic [2:0]  kind;
    logic [31:0] ip;
    kind = pick_kind();
    ip   = pick_ip();
    // persist mostly targets a few fixed addresses so pinned entries stay few
    if (kind == OP_PERSIST && $urandom_range(0, 1) == 0)
      ip = ip_pool[$urandom_range(0, 2)];
    issue(kind, ip, any_mac(), pick_dev());
  endtask

  initial begin
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    phase_age = '{16'd3, 16'd1, 16'd0, 16'd6, 16'd2, 16'd12, 16'd4, 16'hFFFF};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(OP_QRY_IP, '0, '0, '0);
    issue(OP_AGE, '1, '1, '1);
    issue(OP_UPDATE, '0, '0, '0);
    issue(OP_UPDATE, '1, '1, 8'hFF);
    issue(OP_UPDATE, '0, 48'h0123_4567_89AB, 8'h11);
    issue(OP_QRY_IP, '1, '0, '0);
    issue(OP_QRY_DEV, '0, '0, 8'hFF);
    issue(OP_QRY_DEV, '0, '0, 8'h4D);
    issue(OP_PERSIST, '0, '0, '0);
    issue(OP_PERSIST, 32'h0A00_0001, '0, '0);
    issue(OP_UPDATE, '0, '0, '0);
    issue(OP_UNUSED_LO, '1, '1, '1);
    issue(OP_UNUSED_HI, '1, '1, '1);

    // a zero age expires at the very next tick
    set_max_age(16'd0);
    issue(OP_UPDATE, 32'h0A00_0002, any_mac(), 8'h22);
    issue(OP_AGE, '0, '0, '0);

    set_max_age(16'hFFFF);
    issue(OP_UPDATE, 32'h0A00_0003, any_mac(), 8'h33);
    issue(OP_QRY_IP, 32'h0A00_0003, '0, '0);

    // refresh to a short age, fill the table and overflow it
    set_max_age(16'd1);
    issue(OP_UPDATE, 32'h0A00_0003, any_mac(), 8'h33);
    for (int n = 0; n < 14; n++)
      issue(OP_UPDATE, 32'hC0A8_0100 + 32'(n), any_mac(), 8'(n));
    issue(OP_AGE, '0, '0, '0);
    issue(OP_AGE, '0, '0, '0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_max_age(phase_age[p]);
      quiet = (p == PHASE_COUNT - 1);
      repeat (PHASE_ITEMS) random_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/arp_tab_pkg.sv
rtl/core/arp_tab_mem.sv
rtl/core/arp_tab_alu.sv
rtl/core/arp_table_with_aging_top.sv
tb/arp_table_checker.sv
tb/tb_arp_table_with_aging_top.sv
